// ===== hw/rtl/touch_detect_baseline_tracker_top_defines.svh =====
// Assertion macros shared by the touch detect baseline tracker RTL.
`ifndef TOUCH_DETECT_BASELINE_TRACKER_TOP_DEFINES_SVH
`define TOUCH_DETECT_BASELINE_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the cycle after the antecedent.
`define TDBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdbt: next-cycle check failed");
// Consequent must hold in the same cycle as the antecedent.
`define TDBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdbt: same-cycle check failed");
`else
`define TDBT_ASSERT_NEXT(lbl, ante, cons)
`define TDBT_ASSERT_NOW(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/tdbt_pkg.sv =====
// Shared types, constants and helpers for the touch detect baseline tracker.
`default_nettype none
package tdbt_pkg;

  // Width of the filtered level and the baseline
  localparam int COUNT_BITS = 16;
  // Signed working width for differences, counters and limits
  localparam int WIDE_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;
  localparam int LEVEL_W = 16;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;

  // Action codes
  localparam logic [1:0] ACT_MEASURE = 2'd0;
  localparam logic [1:0] ACT_EVAL = 2'd1;
  localparam logic [1:0] ACT_CAL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MARGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_UP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_DOWN = 3'd4;

  // Configuration reset values
  localparam logic [7:0] NOISE_BAND_RST = 8'd2;
  localparam logic [7:0] STEP_MARGIN_RST = 8'd5;
  localparam logic [7:0] PERSIST_RST = 8'd10;
  localparam logic [14:0] DRIFT_UP_RST = 15'd20000;
  localparam logic [14:0] DRIFT_DOWN_RST = 15'd15000;

  localparam logic signed [WIDE_W-1:0] S16_MAX_W = WIDE_W'(32767);
  localparam logic signed [WIDE_W-1:0] S16_MIN_W = -WIDE_W'(32768);

  typedef struct packed {
    logic [7:0]  noise_band;
    logic [7:0]  step_margin;
    logic [7:0]  persist_count;
    logic [14:0] drift_up_limit;
    logic [14:0] drift_down_limit;
  } tdbt_cfg_t;

  typedef struct packed {
    logic                  touch;
    logic [COUNT_BITS-1:0] baseline;
    logic [COUNT_BITS-1:0] filtered;
    logic [CNT_W-1:0]      drift;    // two's complement
    logic [CNT_W-1:0]      persist;  // two's complement
  } tdbt_state_t;

  // Sign-extend a 16-bit two's complement counter to the working width
  function automatic logic signed [WIDE_W-1:0] sext_cnt(input logic [CNT_W-1:0] v);
    return $signed({{(WIDE_W-CNT_W){v[CNT_W-1]}}, v});
  endfunction

  // Saturate a working-width value into a 16-bit signed counter
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic signed [WIDE_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v > S16_MAX_W) begin
      res = CNT_W'(S16_MAX_W);
    end else if (v < S16_MIN_W) begin
      res = CNT_W'(S16_MIN_W);
    end else begin
      res = v[CNT_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tdbt_eval.sv =====
// Next-state logic: filter update, band test, persistence and drift tracking.
`default_nettype none
module tdbt_eval (
  input  wire logic [1:0]          action,
  input  wire logic [15:0]         measurement,
  input  wire tdbt_pkg::tdbt_cfg_t   cfg,
  input  wire tdbt_pkg::tdbt_state_t st,
  output tdbt_pkg::tdbt_state_t      st_nxt
);
  import tdbt_pkg::*;

  logic [COUNT_BITS:0]          filt_sum;
  logic [COUNT_BITS-1:0]        filt_meas;
  logic [COUNT_BITS-1:0]        filt;
  logic [COUNT_BITS-1:0]        raw;
  logic signed [WIDE_W-1:0]     diff_w;
  logic signed [WIDE_W-1:0]     upstep_w;
  logic signed [WIDE_W-1:0]     band_w;
  logic signed [WIDE_W-1:0]     margin_w;
  logic signed [WIDE_W-1:0]     persist_lim_w;
  logic signed [WIDE_W-1:0]     up_lim_w;
  logic signed [WIDE_W-1:0]     down_lim_w;
  logic signed [WIDE_W-1:0]     pers_sum;
  logic signed [WIDE_W-1:0]     drift_sum;
  logic signed [WIDE_W-1:0]     pers_new_w;
  logic signed [WIDE_W-1:0]     drift_new_w;
  logic [CNT_W-1:0]             pers_new;
  logic [CNT_W-1:0]             drift_new;
  logic                         out_band;
  tdbt_state_t                  ev;

  // Averaging filter, used by the measure action only
  assign filt_sum  = {1'b0, st.filtered} + {1'b0, COUNT_BITS'(measurement)};
  assign filt_meas = filt_sum[COUNT_BITS:1];
  assign filt      = (action == ACT_MEASURE) ? filt_meas : st.filtered;

  // Wrapped difference for band/direction/drift, true difference for margin
  assign raw      = filt - st.baseline;
  assign diff_w   = $signed({{(WIDE_W-COUNT_BITS){raw[COUNT_BITS-1]}}, raw});
  assign upstep_w = $signed(WIDE_W'(filt)) - $signed(WIDE_W'(st.baseline));

  assign band_w        = $signed(WIDE_W'(cfg.noise_band));
  assign margin_w      = $signed(WIDE_W'(cfg.step_margin));
  assign persist_lim_w = $signed(WIDE_W'(cfg.persist_count));
  assign up_lim_w      = $signed(WIDE_W'(cfg.drift_up_limit));
  assign down_lim_w    = $signed(WIDE_W'(cfg.drift_down_limit));

  assign out_band = (diff_w > band_w) || (diff_w < -band_w);

  // Saturating counter updates
  assign pers_sum    = sext_cnt(st.persist) +
                       ((diff_w > 0) ? WIDE_W'(1) : -WIDE_W'(1));
  assign pers_new    = clamp_cnt(pers_sum);
  assign pers_new_w  = sext_cnt(pers_new);
  assign drift_sum   = sext_cnt(st.drift) + diff_w;
  assign drift_new   = clamp_cnt(drift_sum);
  assign drift_new_w = sext_cnt(drift_new);

  // Evaluation step
  always_comb begin
    ev = st;
    ev.filtered = filt;
    if (out_band) begin
      ev.persist = pers_new;
      if (pers_new_w > persist_lim_w) begin
        if (upstep_w > margin_w) begin
          ev.touch    = 1'b1;
          ev.baseline = filt;
          ev.persist  = '0;
        end
      end else if (pers_new_w < -persist_lim_w) begin
        if (-upstep_w > margin_w) begin
          ev.touch    = 1'b0;
          ev.baseline = filt;
          ev.persist  = '0;
        end
      end
    end else begin
      ev.persist = '0;
      ev.drift   = drift_new;
      if (drift_new_w > up_lim_w) begin
        ev.baseline = st.baseline + COUNT_BITS'(1);
        ev.drift    = '0;
      end else if (drift_new_w < -down_lim_w) begin
        ev.baseline = st.baseline - COUNT_BITS'(1);
        ev.drift    = '0;
      end
    end
  end

  // Action select; the unused code holds the state
  always_comb begin
    st_nxt = st;
    unique case (action)
      ACT_MEASURE, ACT_EVAL: begin
        st_nxt = ev;
      end
      ACT_CAL: begin
        st_nxt.baseline = st.filtered;
        st_nxt.touch    = 1'b0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/touch_detect_baseline_tracker_top.sv =====
// Top level of the capacitive touch baseline tracker for one pad.
//
// Each accepted transaction (measure+evaluate, evaluate, calibrate or spare)
// is captured in an input register, processed by the next-state logic against
// the tracker state, and its result (touch flag, baseline, filtered level)
// lands in an output register as the transaction advances. One transaction
// per clock is sustained while the output is not stalled; the limit is the
// state update loop, since each transaction reads the state the previous one
// left. A stalled output holds its result while one more transaction waits
// in the input register. Configuration writes are always ready and take
// effect on the next evaluation; indexes beyond the register list are dropped.
`default_nettype none
`include "touch_detect_baseline_tracker_top_defines.svh"
module touch_detect_baseline_tracker_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_action,
  input  wire logic [15:0]                    in_measurement,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_touched,
  output logic [15:0]                         out_baseline_level,
  output logic [15:0]                         out_filtered_level,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tdbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tdbt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tdbt_pkg::*;

  tdbt_cfg_t    cfg_r;
  tdbt_state_t  st_r;
  tdbt_state_t  st_nxt;
  logic         in_vld_r;
  logic [1:0]   in_action_r;
  logic [15:0]  in_meas_r;
  logic         out_vld_r;
  logic         out_touched_r;
  logic [15:0]  out_base_r;
  logic [15:0]  out_filt_r;
  logic         advance;
  logic         in_take;

  // Stage handshake
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.noise_band       <= NOISE_BAND_RST;
      cfg_r.step_margin      <= STEP_MARGIN_RST;
      cfg_r.persist_count    <= PERSIST_RST;
      cfg_r.drift_up_limit   <= DRIFT_UP_RST;
      cfg_r.drift_down_limit <= DRIFT_DOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NOISE_BAND:  cfg_r.noise_band       <= cfg_data[7:0];
        CFG_STEP_MARGIN: cfg_r.step_margin      <= cfg_data[7:0];
        CFG_PERSIST:     cfg_r.persist_count    <= cfg_data[7:0];
        CFG_DRIFT_UP:    cfg_r.drift_up_limit   <= cfg_data[14:0];
        CFG_DRIFT_DOWN:  cfg_r.drift_down_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r <= in_action;
      in_meas_r   <= in_measurement;
    end
  end

  // Next-state logic
  tdbt_eval u_eval (
    .action      (in_action_r),
    .measurement (in_meas_r),
    .cfg         (cfg_r),
    .st          (st_r),
    .st_nxt      (st_nxt)
  );

  // Tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_touched_r <= st_nxt.touch;
      out_base_r    <= LEVEL_W'(st_nxt.baseline);
      out_filt_r    <= LEVEL_W'(st_nxt.filtered);
    end
  end

  assign out_valid          = out_vld_r;
  assign out_touched        = out_touched_r;
  assign out_baseline_level = out_base_r;
  assign out_filtered_level = out_filt_r;

  // Checks
  `TDBT_ASSERT_NEXT(a_adv_gives_result, advance, out_vld_r)
  `TDBT_ASSERT_NEXT(a_held_item_kept, in_vld_r && !advance, in_vld_r)
  `TDBT_ASSERT_NOW(a_out_tracks_state, out_vld_r,
    (out_touched_r == st_r.touch) && (out_base_r == LEVEL_W'(st_r.baseline)))
  `TDBT_ASSERT_NEXT(a_cal_clears_touch, advance && (in_action_r == ACT_CAL), !st_r.touch)

endmodule
`default_nettype wire

// ===== tb/touch_detect_baseline_tracker_scoreboard.sv =====
// Scoreboard for the touch baseline tracker: predicts each report and compares it with the DUT.
`timescale 1ns / 100ps
module touch_detect_baseline_tracker_scoreboard (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [15:0]                    in_measurement,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_touched,
  input  logic [15:0]                    out_baseline_level,
  input  logic [15:0]                    out_filtered_level,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tdbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdbt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             pending_count
);
  import tdbt_pkg::*;

  typedef struct packed {
    logic        touched;
    logic [15:0] baseline;
    logic [15:0] filtered;
  } pad_report_t;

  pad_report_t expected_reports[$];

  // Shadow copy of the tracker state
  logic [15:0]        filt_lvl;
  logic [15:0]        base_lvl;
  logic signed [15:0] drift_acc;
  logic signed [15:0] persist_cnt;
  logic               touch_st;

  // Shadow copy of the configuration registers
  logic [7:0]  band_cfg;
  logic [7:0]  margin_cfg;
  logic [7:0]  persist_cfg;
  logic [14:0] up_lim_cfg;
  logic [14:0] down_lim_cfg;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // One comparison of the filtered level against the baseline
  task automatic evaluate_level();
    logic signed [15:0] wrapped;
    int diff, up_step, band, pc, cnt, acc, upl, dnl;
    wrapped = filt_lvl - base_lvl;
    diff    = wrapped;
    up_step = int'(filt_lvl) - int'(base_lvl);
    band    = band_cfg;
    pc      = persist_cfg;
    upl     = up_lim_cfg;
    dnl     = down_lim_cfg;
    if (diff > band || diff < -band) begin
      // outside the noise band: persistence steps toward the sign
      cnt = persist_cnt;
      persist_cnt = sat16(cnt + ((diff > 0) ? 1 : -1));
      cnt = persist_cnt;
      if (cnt > pc) begin
        if (up_step > int'(margin_cfg)) begin
          touch_st    = 1'b1;
          base_lvl    = filt_lvl;
          persist_cnt = '0;
        end
      end else if (cnt < -pc) begin
        if (-up_step > int'(margin_cfg)) begin
          touch_st    = 1'b0;
          base_lvl    = filt_lvl;
          persist_cnt = '0;
        end
      end
    end else begin
      // inside the band: integrate drift, nudge baseline past a limit
      persist_cnt = '0;
      acc = drift_acc;
      drift_acc = sat16(acc + diff);
      acc = drift_acc;
      if (acc > upl) begin
        base_lvl  = base_lvl + 16'd1;
        drift_acc = '0;
      end else if (acc < -dnl) begin
        base_lvl  = base_lvl - 16'd1;
        drift_acc = '0;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input pad_report_t want,
                               input pad_report_t got);
    if (mismatch_count < 10) begin
      $display("%0t: %s: expected t=%0b b=%0d f=%0d, got t=%0b b=%0d f=%0d",
               $time, what, want.touched, want.baseline, want.filtered,
               got.touched, got.baseline, got.filtered);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    pad_report_t got;
    pad_report_t want;
    int sum;
    if (!rst_n) begin
      filt_lvl     = '0;
      base_lvl     = '0;
      drift_acc    = '0;
      persist_cnt  = '0;
      touch_st     = 1'b0;
      band_cfg     = NOISE_BAND_RST;
      margin_cfg   = STEP_MARGIN_RST;
      persist_cfg  = PERSIST_RST;
      up_lim_cfg   = DRIFT_UP_RST;
      down_lim_cfg = DRIFT_DOWN_RST;
      expected_reports.delete();
    end else begin
      // results leaving the block belong to transactions already accepted
      if (out_valid && !out_stall) begin
        got.touched  = out_touched;
        got.baseline = out_baseline_level;
        got.filtered = out_filtered_level;
        if (expected_reports.size() == 0) begin
          want = '0;
          note_mismatch("unexpected report", want, got);
        end else begin
          want = expected_reports.pop_front();
          if (got.touched !== want.touched || got.baseline !== want.baseline ||
              got.filtered !== want.filtered) begin
            note_mismatch("report mismatch", want, got);
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NOISE_BAND:  band_cfg     = cfg_data[7:0];
          CFG_STEP_MARGIN: margin_cfg   = cfg_data[7:0];
          CFG_PERSIST:     persist_cfg  = cfg_data[7:0];
          CFG_DRIFT_UP:    up_lim_cfg   = cfg_data[14:0];
          CFG_DRIFT_DOWN:  down_lim_cfg = cfg_data[14:0];
          default: ;
        endcase
      end

      // new transaction: advance the shadow state and queue its report
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_MEASURE: begin
            sum = int'(filt_lvl) + int'(in_measurement);
            filt_lvl = 16'(sum >> 1);
            evaluate_level();
          end
          ACT_EVAL: evaluate_level();
          ACT_CAL: begin
            base_lvl = filt_lvl;
            touch_st = 1'b0;
          end
          default: ;
        endcase
        want.touched  = touch_st;
        want.baseline = base_lvl;
        want.filtered = filt_lvl;
        expected_reports.push_back(want);
      end
    end
    pending_count = expected_reports.size();
  end

endmodule

// ===== tb/touch_detect_baseline_tracker_top_test.sv =====
// Testbench top for the touch baseline tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module touch_detect_baseline_tracker_top_test;
  import tdbt_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AFTER_ITEMS = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = '0;
  logic [15:0]           in_measurement = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_touched;
  logic [15:0]           out_baseline_level;
  logic [15:0]           out_filtered_level;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_count;
  int pending_count;

  // Idle rates and the one long receiver hold-off
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int cycle_cnt = 0;

  // Traffic shaping follows the configuration in force
  int band_now = NOISE_BAND_RST;
  int margin_now = STEP_MARGIN_RST;
  int persist_now = PERSIST_RST;
  int level_now = 0;
  int phase_items = 0;

  touch_detect_baseline_tracker_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_measurement     (in_measurement),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_touched        (out_touched),
    .out_baseline_level (out_baseline_level),
    .out_filtered_level (out_filtered_level),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  touch_detect_baseline_tracker_scoreboard report_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_measurement     (in_measurement),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_touched        (out_touched),
    .out_baseline_level (out_baseline_level),
    .out_filtered_level (out_filtered_level),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .pending_count      (pending_count)
  );

  always #4 clk = ~clk;

  // Run-length guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off once the sender is busy
  always @(negedge clk) begin
    if (hold_req && !hold_taken && phase_items >= HOLD_AFTER_ITEMS &&
        phase_items < PHASE_ITEMS) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic [15:0] clip16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic int jitter();
    return int'($urandom_range(4)) - 2;
  endfunction

  // Pad levels: mostly anywhere, sometimes hugging either rail
  function automatic int pick_level();
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom_range(300);
    if (r == 1) return $urandom_range(65535, 65235);
    return $urandom_range(65535);
  endfunction

  // One transaction on the input channel; returns once it is accepted
  task automatic send_item(input logic [1:0] act, input logic [15:0] meas);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_measurement <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act != ACT_SPARE) phase_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(input int band, input int margin, input int persist,
                              input int up_lim, input int down_lim);
    write_reg(CFG_NOISE_BAND, CFG_DATA_W'(band));
    write_reg(CFG_STEP_MARGIN, CFG_DATA_W'(margin));
    write_reg(CFG_PERSIST, CFG_DATA_W'(persist));
    write_reg(CFG_DRIFT_UP, CFG_DATA_W'(up_lim));
    write_reg(CFG_DRIFT_DOWN, CFG_DATA_W'(down_lim));
    @(negedge clk);
    cfg_valid  <= 1'b0;
    band_now    = band;
    margin_now  = margin;
    persist_now = persist;
  endtask

  // Stop offering, wait for every report, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_level(input int lvl);
    if ($urandom_range(3) == 0) send_item(ACT_EVAL, 16'($urandom));
    else send_item(ACT_MEASURE, clip16(lvl + jitter()));
  endtask

  // Settle on a level, calibrate, press long enough to qualify, release
  task automatic press_episode();
    int lvl, delta, hold;
    lvl = pick_level();
    repeat ($urandom_range(8, 3)) send_item(ACT_MEASURE, clip16(lvl + jitter()));
    send_item(ACT_CAL, 16'($urandom));
    delta = $urandom_range(margin_now + band_now + 400);
    if ($urandom_range(9) < 3) delta = -delta;
    hold = persist_now + $urandom_range(10, 2);
    repeat (hold) push_level(lvl + delta);
    repeat (hold) push_level(lvl);
    level_now = lvl;
  endtask

  // Small offsets inside the noise band so the drift accumulator works
  task automatic drift_episode();
    int off;
    repeat (3) send_item(ACT_MEASURE, clip16(level_now));
    send_item(ACT_CAL, 16'($urandom));
    off = int'($urandom_range(2 * band_now)) - band_now;
    repeat ($urandom_range(60, 10)) push_level(level_now + off);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(6, 1)) send_item(2'($urandom), 16'($urandom));
  endtask

  task automatic run_phase(input int band, input int margin, input int persist,
                           input int up_lim, input int down_lim,
                           input int tx_pct, input int rx_pct, input bit spare_writes);
    int sel;
    drain();
    if (spare_writes) begin
      for (int i = CFG_UNMAPPED_LO; i <= CFG_UNMAPPED_HI; i++) begin
        write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
      end
    end
    write_config(band, margin, persist, up_lim, down_lim);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 50) press_episode();
      else if (sel < 75) drift_episode();
      else noise_burst();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 23;
    rx_idle_pct = 56;

    // directed: rails, measure and evaluate, the spare action, reset configuration
    send_item(ACT_MEASURE, 16'hFFFF);
    send_item(ACT_EVAL, 16'h0000);
    send_item(ACT_SPARE, 16'hFFFF);
    drain();

    // directed: wide band with zero drift limits, calibration near the top rail
    write_config(255, 5, 10, 0, 0);
    repeat (8) send_item(ACT_MEASURE, 16'hFFFF);
    send_item(ACT_CAL, 16'h1234);
    send_item(ACT_MEASURE, 16'h0000);
    send_item(ACT_MEASURE, 16'h0000);
    send_item(ACT_EVAL, 16'hFFFF);
    send_item(ACT_SPARE, 16'h0000);
    send_item(ACT_MEASURE, 16'h5555);
    send_item(ACT_MEASURE, 16'hAAAA);
    send_item(ACT_CAL, 16'h0000);
    send_item(ACT_EVAL, 16'h0000);

    // random phases: receiver-light, sender-light, then full rate
    run_phase(0, 0, 0, 0, 0, 23, 56, 1'b0);
    run_phase(3, 8, 4, 300, 200, 23, 56, 1'b0);
    run_phase(255, 255, 255, 32767, 32767, 56, 23, 1'b0);
    run_phase(10, 20, 2, 50, 4000, 56, 23, 1'b1);
    run_phase(1, 100, 12, 32767, 0, 0, 0, 1'b0);
    hold_req <= 1'b1;
    run_phase(40, 2, 6, 1000, 1000, 0, 0, 1'b0);

    drain();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tdbt_pkg.sv
hw/rtl/tdbt_eval.sv
hw/rtl/touch_detect_baseline_tracker_top.sv
tb/touch_detect_baseline_tracker_scoreboard.sv
tb/touch_detect_baseline_tracker_top_test.sv
